/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by an active-low reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, gated by an active-low reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/hcd_pkg.sv */
package hcd_pkg;

  localparam int BOOK_ENTRIES = 16;
  localparam int MAX_CODE_LEN = 16;
  localparam int SYMBOL_BITS  = 8;

  localparam int BOOK_IDX_W = $clog2(BOOK_ENTRIES);
  localparam int ACT_W      = 2;
  localparam int IDX_W      = 4;
  localparam int CODE_W     = 16;
  localparam int LEN_W      = 5;
  localparam int SYM_W      = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD = 2'd0,
    ACT_BIT  = 2'd1,
    ACT_END  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_SYMBOL       = 2'd0,
    ST_NOMATCH      = 2'd1,
    ST_CLEAN_END    = 2'd2,
    ST_LEFTOVER_END = 2'd3
  } status_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  entry_index;
    logic [CODE_W-1:0] entry_code;
    logic [LEN_W-1:0]  entry_length;
    logic [SYM_W-1:0]  entry_symbol;
    logic              code_bit;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    status_e          status;
    logic [LEN_W-1:0] code_length;
  } out_item_t;

  // codebook write port
  typedef struct packed {
    logic                   en;
    logic [BOOK_IDX_W-1:0]  index;
    logic [CODE_W-1:0]      code;
    logic [LEN_W-1:0]       length;
    logic [SYMBOL_BITS-1:0] symbol;
  } book_wr_t;

  // prefix presented to the codebook for matching
  typedef struct packed {
    logic [LEN_W-1:0]  count;
    logic [CODE_W-1:0] bits;
    logic [CODE_W-1:0] mask;
  } prefix_t;

  typedef struct packed {
    logic                   hit;
    logic [SYMBOL_BITS-1:0] symbol;
  } book_hit_t;

  typedef struct packed {
    logic      load;
    out_item_t item;
  } res_ctl_t;

endpackage

/* rtl/core/hcd_in_if.sv */
interface hcd_in_if import hcd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/hcd_out_if.sv */
interface hcd_out_if import hcd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/hcd_book.sv */
module hcd_book import hcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  book_wr_t  wr_i,
  input  prefix_t   query_i,
  output book_hit_t hit_o
);

  logic [LEN_W-1:0]       length_q [BOOK_ENTRIES];
  logic [CODE_W-1:0]      code_q   [BOOK_ENTRIES];
  logic [SYMBOL_BITS-1:0] symbol_q [BOOK_ENTRIES];

  // zero length marks a slot unused, so only lengths need a reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BOOK_ENTRIES; i++) begin
        length_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      length_q[wr_i.index] <= wr_i.length;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      code_q[wr_i.index]   <= wr_i.code;
      symbol_q[wr_i.index] <= wr_i.symbol;
    end
  end

  // parallel compare; later slots override earlier ones
  always_comb begin
    hit_o = '0;
    for (int i = 0; i < BOOK_ENTRIES; i++) begin
      if (length_q[i] != '0 && length_q[i] == query_i.count &&
          (code_q[i] & query_i.mask) == query_i.bits) begin
        hit_o.hit    = 1'b1;
        hit_o.symbol = symbol_q[i];
      end
    end
  end

endmodule

/* rtl/core/hcd_result.sv */
module hcd_result import hcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_ctl_t  ctl_i,
  output logic      free_o,
  hcd_out_if.source out_o
);

  logic      valid_q;
  out_item_t data_q;

  assign free_o      = !valid_q || out_o.ready;
  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      data_q <= ctl_i.item;
    end
  end

endmodule

/* rtl/core/prefix_code_decoder_top.sv */
// Prefix-code decoder: one item per clock, sustained while results are taken.
// An accepted item sits in an input register, where the pending prefix plus
// the new bit is compared against all 16 codebook slots at once; a match, a
// no-match at 16 bits, or an end of stream loads the result register, from
// which the result is presented. The parallel compare is combinational and
// sets the rate. Codebook loads take effect for the very next item. A result
// that is not taken stalls only items that produce a result; the input stays
// open while the input register can drain.
module prefix_code_decoder_top import hcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  hcd_in_if.sink    in_i,
  hcd_out_if.source out_o
);

  logic              s1_valid_q;
  in_item_t          s1_q;
  logic [LEN_W-1:0]  count_q, count_d;
  logic [CODE_W-1:0] bits_q, bits_d;

  logic              res_free;
  logic              advance;
  logic              produces;
  logic              full;
  logic [LEN_W-1:0]  count_nxt;
  logic [CODE_W-1:0] mask_nxt;
  logic [CODE_W-1:0] bits_nxt;
  prefix_t           query;
  book_hit_t         hit;
  book_wr_t          book_wr;
  res_ctl_t          res_ctl;

  assign count_nxt = count_q + LEN_W'(1);
  assign mask_nxt  = ~({CODE_W{1'b1}} << count_nxt);
  assign bits_nxt  = {bits_q[CODE_W-2:0], s1_q.code_bit} & mask_nxt;
  assign full      = count_nxt >= LEN_W'(MAX_CODE_LEN);

  assign query = '{count: count_nxt, bits: bits_nxt, mask: mask_nxt};

  assign produces = (s1_q.action == ACT_END) ||
                    (s1_q.action == ACT_BIT && (hit.hit || full));
  assign advance  = s1_valid_q && (!produces || res_free);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      count_q    <= '0;
      bits_q     <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      count_q <= count_d;
      bits_q  <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= in_i.data;
    end
  end

  always_comb begin
    book_wr        = '0;
    book_wr.en     = advance && s1_q.action == ACT_LOAD;
    book_wr.index  = s1_q.entry_index[BOOK_IDX_W-1:0];
    book_wr.code   = s1_q.entry_code;
    book_wr.length = s1_q.entry_length;
    book_wr.symbol = s1_q.entry_symbol[SYMBOL_BITS-1:0];
  end

  always_comb begin
    count_d = count_q;
    bits_d  = bits_q;
    res_ctl = '0;
    if (advance) begin
      case (s1_q.action)
        ACT_BIT: begin
          if (hit.hit) begin
            res_ctl.load             = 1'b1;
            res_ctl.item.symbol      = SYM_W'(hit.symbol);
            res_ctl.item.status      = ST_SYMBOL;
            res_ctl.item.code_length = count_nxt;
            count_d = '0;
            bits_d  = '0;
          end else if (full) begin
            res_ctl.load             = 1'b1;
            res_ctl.item.status      = ST_NOMATCH;
            res_ctl.item.code_length = count_nxt;
            count_d = '0;
            bits_d  = '0;
          end else begin
            count_d = count_nxt;
            bits_d  = bits_nxt;
          end
        end
        ACT_END: begin
          res_ctl.load             = 1'b1;
          res_ctl.item.status      = (count_q == '0) ? ST_CLEAN_END : ST_LEFTOVER_END;
          res_ctl.item.code_length = count_q;
          count_d = '0;
          bits_d  = '0;
        end
        default: ;
      endcase
    end
  end

  hcd_book u_book (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (book_wr),
    .query_i (query),
    .hit_o   (hit)
  );

  hcd_result u_result (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (res_ctl),
    .free_o (res_free),
    .out_o  (out_o)
  );

endmodule

/* rtl/core/hcd_checker.sv */
`include "assert_macros.svh"

module hcd_checker import hcd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [SYM_W-1:0] out_symbol_i,
  input status_e          out_status_i,
  input logic [LEN_W-1:0] out_length_i
);

  logic [SYM_W+LEN_W+1:0] out_word;
  logic                   stalled;
  logic                   clean_v;
  logic                   nomatch_v;
  logic                   symbol_v;
  logic                   nomatch_ok;
  logic                   symbol_ok;

  assign out_word   = {out_symbol_i, out_status_i, out_length_i};
  assign stalled    = out_valid_i && !out_ready_i;
  assign clean_v    = out_valid_i && out_status_i == ST_CLEAN_END;
  assign nomatch_v  = out_valid_i && out_status_i == ST_NOMATCH;
  assign symbol_v   = out_valid_i && out_status_i == ST_SYMBOL;
  assign nomatch_ok = out_length_i == LEN_W'(MAX_CODE_LEN) && out_symbol_i == '0;
  assign symbol_ok  = out_length_i != '0 && out_length_i <= LEN_W'(MAX_CODE_LEN);

  // stalled result must hold
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_i)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, stalled, $stable(out_word))

  // field consistency per status
  `ASSERT_IMP(a_clean_len, clk_i, rst_ni, clean_v, out_length_i == '0)
  `ASSERT_IMP(a_nomatch_len, clk_i, rst_ni, nomatch_v, nomatch_ok)
  `ASSERT_IMP(a_symbol_len, clk_i, rst_ni, symbol_v, symbol_ok)

endmodule

bind prefix_code_decoder_top hcd_checker u_hcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_symbol_i (out_o.data.symbol),
  .out_status_i (out_o.data.status),
  .out_length_i (out_o.data.code_length)
);
